[design/vn3_pkg.sv]
// shared constants for the 3d value noise core
// hash multipliers, shift amounts and pipeline latencies; no dependencies
package vn3_pkg;

    localparam int HASH_W = 64;
    localparam int HALF_W = HASH_W / 2;

    localparam int FRAC_BITS_DEF     = 16;
    localparam int CELL_INT_BITS_DEF = 32;

    // finalizer multipliers and shifts
    localparam logic [HASH_W-1:0] MUL_A = 64'hbf58476d1ce4e5b9;
    localparam logic [HASH_W-1:0] MUL_B = 64'h94d049bb133111eb;
    localparam int SHR_A = 30;
    localparam int SHR_B = 27;
    localparam int SHR_C = 31;

    // per-axis lattice multipliers, x then y then z
    localparam int N_AXIS = 3;
    localparam logic [HASH_W-1:0] AXIS_MUL [N_AXIS] = '{
        64'h9e3779b185ebca87,
        64'hc2b2ae3d27d4eb4f,
        64'h165667b19e3779f9
    };

    // stage counts of the building blocks
    localparam int MUL_LAT  = 2;
    localparam int SCR_LAT  = 2 * MUL_LAT;
    localparam int FADE_LAT = 3;

endpackage

[design/vn3_ifs.sv]
// valid/ready channel interfaces of the 3d value noise core
// coordinate channel and noise channel; no dependencies
interface vn3_coord_if #(
    parameter int COORD_W = 48
);
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;

    modport source (output valid, output coord_x, output coord_y, output coord_z,
                    input ready);
    modport sink   (input valid, input coord_x, input coord_y, input coord_z,
                    output ready);
endinterface

interface vn3_noise_if #(
    parameter int OUT_W = 17
);
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] noise_out;

    modport source (output valid, output noise_out, input ready);
    modport sink   (input valid, input noise_out, output ready);
endinterface

[design/vn3_mul64.sv]
// 64-bit by constant multiply, low 64 bits kept, two stages
// 32-bit partial products then their sum; uses vn3_pkg
module vn3_mul64 #(
    parameter logic [63:0] K = 64'd1
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [vn3_pkg::HASH_W-1:0]  i_a,
    output logic [vn3_pkg::HASH_W-1:0]  o_p
);
    import vn3_pkg::*;

    localparam logic [HALF_W-1:0] K_LO = K[HALF_W-1:0];
    localparam logic [HALF_W-1:0] K_HI = K[HASH_W-1:HALF_W];

    logic [HASH_W-1:0] w_ll;
    logic [HALF_W-1:0] w_lh;
    logic [HALF_W-1:0] w_hl;
    logic [HASH_W-1:0] r_ll;
    logic [HALF_W-1:0] r_lh;
    logic [HALF_W-1:0] r_hl;
    logic [HALF_W-1:0] w_cross;
    logic [HASH_W-1:0] r_p;

    assign w_ll    = HASH_W'(i_a[HALF_W-1:0]) * HASH_W'(K_LO);
    assign w_lh    = i_a[HALF_W-1:0] * K_HI;
    assign w_hl    = i_a[HASH_W-1:HALF_W] * K_LO;
    assign w_cross = r_lh + r_hl;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll <= w_ll;
            r_lh <= w_lh;
            r_hl <= w_hl;
            r_p  <= r_ll + {w_cross, {HALF_W{1'b0}}};
        end
    end

    assign o_p = r_p;

endmodule

[design/vn3_scramble.sv]
// one multiply-xorshift finalizer round, four stages
// two vn3_mul64 stages; uses vn3_pkg
module vn3_scramble (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [vn3_pkg::HASH_W-1:0]  i_v,
    output logic [vn3_pkg::HASH_W-1:0]  o_v
);
    import vn3_pkg::*;

    logic [HASH_W-1:0] w_sa;
    logic [HASH_W-1:0] w_ma;
    logic [HASH_W-1:0] w_sb;
    logic [HASH_W-1:0] w_mb;

    assign w_sa = i_v ^ (i_v >> SHR_A);

    vn3_mul64 #(.K(MUL_A)) u_mul_a (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (w_sa),
        .o_p   (w_ma)
    );

    assign w_sb = w_ma ^ (w_ma >> SHR_B);

    vn3_mul64 #(.K(MUL_B)) u_mul_b (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (w_sb),
        .o_p   (w_mb)
    );

    assign o_v = w_mb ^ (w_mb >> SHR_C);

endmodule

[design/vn3_fade.sv]
// quintic fade 6t^5-15t^4+10t^3 in q0.frac, three stages
// truncating shifts after each product; uses vn3_pkg
module vn3_fade #(
    parameter int FRAC_BITS = vn3_pkg::FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [FRAC_BITS-1:0] i_t,
    output logic [FRAC_BITS-1:0] o_w
);
    import vn3_pkg::*;

    localparam int SQ_W = 2 * FRAC_BITS;
    localparam int P_W  = FRAC_BITS + 4;
    localparam int PC_W = P_W + 1;
    localparam int FW_W = SQ_W + 4;

    logic [SQ_W-1:0]      w_sq;
    logic [SQ_W-1:0]      w_cu;
    logic [PC_W-1:0]      w_p;
    logic [FW_W-1:0]      w_fw;
    logic [FRAC_BITS-1:0] r_t1;
    logic [FRAC_BITS-1:0] r_t2;
    logic [FRAC_BITS-1:0] r_t3;
    logic [P_W-1:0]       r_p;
    logic [FRAC_BITS-1:0] r_w;

    assign w_sq = SQ_W'(i_t) * SQ_W'(i_t);
    assign w_cu = SQ_W'(r_t2) * SQ_W'(r_t1);
    // 6*t2 + 10 - 15*t, always positive and below 2^(frac+4)
    assign w_p  = PC_W'(r_t2) * PC_W'(6) + (PC_W'(10) << FRAC_BITS)
                - PC_W'(r_t1) * PC_W'(15);
    assign w_fw = FW_W'(r_t3) * FW_W'(r_p);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t1 <= i_t;
            r_t2 <= w_sq[SQ_W-1:FRAC_BITS];
            r_t3 <= w_cu[SQ_W-1:FRAC_BITS];
            r_p  <= w_p[P_W-1:0];
            r_w  <= w_fw[SQ_W-1:FRAC_BITS];
        end
    end

    assign o_w = r_w;

endmodule

[design/vn3_delay.sv]
// fixed-length shift line with a common advance enable
// carries side data alongside the hash rounds; no dependencies
module vn3_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_d
);
    logic [WIDTH-1:0] r_tap [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tap[0] <= i_d;
            for (int i = 1; i < DEPTH; i++) begin
                r_tap[i] <= r_tap[i-1];
            end
        end
    end

    assign o_d = r_tap[DEPTH-1];

endmodule

[design/value_noise_3d_hashed_lattice_core.sv]
// throughput: one transaction per cycle while the output is not stalled; the chain of seven 64-bit multiplies
// (axis product plus three finalizer rounds of two, each split into 32-bit
// partial products over two stages) sets the depth
// a stall at the output freezes every stage, the last stage is the output register
// reset (synchronous, active low) clears the stage valid bits and sets the seed to zero
module value_noise_3d_hashed_lattice_core #(
    parameter int FRAC_BITS     = vn3_pkg::FRAC_BITS_DEF,
    parameter int CELL_INT_BITS = vn3_pkg::CELL_INT_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [vn3_pkg::HASH_W-1:0]  i_cfg_wr_data,
    vn3_coord_if.sink                   i_coord,
    vn3_noise_if.source                 o_noise
);
    import vn3_pkg::*;

    localparam int COORD_W = CELL_INT_BITS + FRAC_BITS;
    localparam int OUT_W   = FRAC_BITS + 1;
    localparam int EXT_W   = HASH_W - CELL_INT_BITS;

    // stage index at which each group of values sits in registers
    localparam int T_AXIS   = MUL_LAT + 1;
    localparam int T_X      = T_AXIS + SCR_LAT;
    localparam int T_Y      = T_X + SCR_LAT;
    localparam int T_Z      = T_Y + SCR_LAT;
    localparam int T_CV     = T_Z + 1;
    localparam int PIPE_LAT = T_CV + 3;

    // seed register; the user must write it only while idle, the block does not enforce this
    logic [HASH_W-1:0] r_seed;

    // global advance: move when the output is empty or being taken
    logic                w_en;
    logic [PIPE_LAT-1:0] r_vld;

    logic [HASH_W-1:0]    w_cell  [N_AXIS];
    logic [FRAC_BITS-1:0] w_frac  [N_AXIS];
    logic [HASH_W-1:0]    w_prod  [N_AXIS];
    logic [HASH_W-1:0]    r_pa    [N_AXIS][2];
    logic [FRAC_BITS-1:0] w_fade  [N_AXIS];
    logic [FRAC_BITS-1:0] w_wd    [N_AXIS];

    logic [HASH_W-1:0] w_py_d [2];
    logic [HASH_W-1:0] w_pz_d [2];
    logic [HASH_W-1:0] w_hx   [2];
    logic [HASH_W-1:0] w_hy   [4];
    logic [HASH_W-1:0] w_hz   [8];

    logic signed [OUT_W-1:0] r_cv [8];
    logic signed [OUT_W-1:0] r_bx [4];
    logic signed [OUT_W-1:0] r_by [2];
    logic signed [OUT_W-1:0] r_noise;

    // a + floor((b - a) * w / 2^frac), stays between a and b
    function automatic logic signed [OUT_W-1:0] blend(
        input logic signed [OUT_W-1:0] a,
        input logic signed [OUT_W-1:0] b,
        input logic [FRAC_BITS-1:0]    w
    );
        logic signed [OUT_W:0]           diff;
        logic signed [OUT_W+FRAC_BITS+1:0] prod;
        logic signed [OUT_W+FRAC_BITS+1:0] sh;
        logic [OUT_W:0]                  sum;
        diff = (OUT_W+1)'(b) - (OUT_W+1)'(a);
        prod = (OUT_W+FRAC_BITS+2)'(diff) * $signed({1'b0, w});
        sh   = prod >>> FRAC_BITS;
        sum  = (OUT_W+1)'(a) + sh[OUT_W:0];
        return sum[OUT_W-1:0];
    endfunction

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (i_cfg_wr_en) begin
            r_seed <= i_cfg_wr_data;
        end
    end

    assign w_en          = !r_vld[PIPE_LAT-1] || o_noise.ready;
    assign i_coord.ready = w_en;

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PIPE_LAT-2:0], i_coord.valid};
        end
    end

    // split each coordinate into floor cell (sign extended to 64) and fraction
    assign w_cell[0] = {{EXT_W{i_coord.coord_x[COORD_W-1]}},
                        i_coord.coord_x[COORD_W-1:FRAC_BITS]};
    assign w_cell[1] = {{EXT_W{i_coord.coord_y[COORD_W-1]}},
                        i_coord.coord_y[COORD_W-1:FRAC_BITS]};
    assign w_cell[2] = {{EXT_W{i_coord.coord_z[COORD_W-1]}},
                        i_coord.coord_z[COORD_W-1:FRAC_BITS]};
    assign w_frac[0] = i_coord.coord_x[FRAC_BITS-1:0];
    assign w_frac[1] = i_coord.coord_y[FRAC_BITS-1:0];
    assign w_frac[2] = i_coord.coord_z[FRAC_BITS-1:0];

    genvar a;
    generate
        for (a = 0; a < N_AXIS; a++) begin : g_axis
            // cell * axis multiplier
            vn3_mul64 #(.K(AXIS_MUL[a])) u_axis_mul (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_a   (w_cell[a]),
                .o_p   (w_prod[a])
            );

            // fade runs beside the hash rounds
            vn3_fade #(.FRAC_BITS(FRAC_BITS)) u_fade (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_t   (w_frac[a]),
                .o_w   (w_fade[a])
            );

            // weight for axis a is consumed one stage after the previous axis
            vn3_delay #(.WIDTH(FRAC_BITS), .DEPTH(T_CV - FADE_LAT + a)) u_w_dly (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_d   (w_fade[a]),
                .o_d   (w_wd[a])
            );

            // (cell + 1) * K is cell * K + K modulo 2^64
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_pa[a][0] <= w_prod[a];
                    r_pa[a][1] <= w_prod[a] + AXIS_MUL[a];
                end
            end
        end
    endgenerate

    // line up y and z axis products with the end of the previous round
    vn3_delay #(.WIDTH(2 * HASH_W), .DEPTH(T_X - T_AXIS)) u_py_dly (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   ({r_pa[1][1], r_pa[1][0]}),
        .o_d   ({w_py_d[1], w_py_d[0]})
    );

    vn3_delay #(.WIDTH(2 * HASH_W), .DEPTH(T_Y - T_AXIS)) u_pz_dly (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   ({r_pa[2][1], r_pa[2][0]}),
        .o_d   ({w_pz_d[1], w_pz_d[0]})
    );

    genvar g;
    generate
        // x round: one lane per dx
        for (g = 0; g < 2; g++) begin : g_xr
            vn3_scramble u_scr (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_v   (r_seed ^ r_pa[0][g]),
                .o_v   (w_hx[g])
            );
        end
        // y round: lane index dy*2+dx
        for (g = 0; g < 4; g++) begin : g_yr
            vn3_scramble u_scr (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_v   (w_hx[g % 2] ^ w_py_d[g / 2]),
                .o_v   (w_hy[g])
            );
        end
        // z round: lane index dz*4+dy*2+dx
        for (g = 0; g < 8; g++) begin : g_zr
            vn3_scramble u_scr (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_v   (w_hy[g % 4] ^ w_pz_d[g / 4]),
                .o_v   (w_hz[g])
            );
        end
    endgenerate

    // corner value: top frac+1 hash bits minus 2^frac, i.e. flip the top bit
    // then trilinear blend, x then y then z, one stage each
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 8; i++) begin
                r_cv[i] <= {~w_hz[i][HASH_W-1], w_hz[i][HASH_W-2:HASH_W-1-FRAC_BITS]};
            end
            for (int j = 0; j < 4; j++) begin
                r_bx[j] <= blend(r_cv[2*j], r_cv[2*j+1], w_wd[0]);
            end
            for (int k = 0; k < 2; k++) begin
                r_by[k] <= blend(r_bx[2*k], r_bx[2*k+1], w_wd[1]);
            end
            r_noise <= blend(r_by[0], r_by[1], w_wd[2]);
        end
    end

    assign o_noise.valid     = r_vld[PIPE_LAT-1];
    assign o_noise.noise_out = r_noise;

endmodule
